// ----- rtl/core/lkvc_pkg.sv -----
// Shared types and constants for the LRU key/value cache core.
// No dependencies; every other file in rtl/core uses this package.
package lkvc_pkg;

    localparam int KEY_W       = 32;
    localparam int VALUE_W     = 32;
    localparam int CAP_W       = 5;
    localparam int ENTRIES_DEF = 16;
    localparam int QUEUE_DEPTH = 2;   // power of two
    localparam int PADDR_W     = 3;
    localparam int PDATA_W     = 32;

    localparam logic [CAP_W-1:0]   CAP_RESET    = 5'd16;
    localparam logic [VALUE_W-1:0] MISS_DATA    = '1;
    localparam logic [0:0]         REG_CAPACITY = 1'b0;

    typedef enum logic {
        OP_GET = 1'b0,
        OP_PUT = 1'b1
    } t_op;

    typedef struct packed {
        t_op                      op;
        logic signed [KEY_W-1:0]  key;
        logic signed [VALUE_W-1:0] value;
    } t_req;

    typedef enum logic [1:0] {
        ST_MATCH,
        ST_UPDATE,
        ST_RESP
    } t_back_state;

endpackage

// ----- rtl/core/lkvc_front.sv -----
// Front end: accepts requests from the input channel and decodes them.
// Depends on lkvc_pkg; feeds lkvc_queue.
module lkvc_front (
    input  logic                              i_clk,
    input  logic                              i_rst_n,
    input  logic                              i_valid,
    output logic                              o_stall,
    input  logic                              i_kind,
    input  logic signed [lkvc_pkg::KEY_W-1:0]   i_key,
    input  logic signed [lkvc_pkg::VALUE_W-1:0] i_value,
    input  logic                              i_q_full,
    output logic                              o_push,
    output lkvc_pkg::t_req                    o_req
);

    logic           r_valid;
    lkvc_pkg::t_req r_req;
    logic           accept;

    assign o_stall = r_valid & i_q_full;
    assign accept  = i_valid & ~o_stall;
    assign o_push  = r_valid & ~i_q_full;
    assign o_req   = r_req;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (accept) begin
            r_valid <= 1'b1;
        end else if (o_push) begin
            r_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (accept) begin
            r_req.op    <= i_kind ? lkvc_pkg::OP_PUT : lkvc_pkg::OP_GET;
            r_req.key   <= i_key;
            r_req.value <= i_value;
        end
    end

endmodule

// ----- rtl/core/lkvc_queue.sv -----
// Short request queue between the front end and the back end.
// Depends on lkvc_pkg (request type and depth).
module lkvc_queue (
    input  logic           i_clk,
    input  logic           i_rst_n,
    input  logic           i_push,
    input  lkvc_pkg::t_req i_req,
    output logic           o_full,
    input  logic           i_pop,
    output logic           o_valid,
    output lkvc_pkg::t_req o_req
);

    localparam int PW = (lkvc_pkg::QUEUE_DEPTH > 1) ? $clog2(lkvc_pkg::QUEUE_DEPTH) : 1;
    localparam int CW = $clog2(lkvc_pkg::QUEUE_DEPTH + 1);

    lkvc_pkg::t_req r_slot [lkvc_pkg::QUEUE_DEPTH];
    logic [PW-1:0]  r_wptr;
    logic [PW-1:0]  r_rptr;
    logic [CW-1:0]  r_count;
    logic           do_push;
    logic           do_pop;

    assign o_full  = (r_count == CW'(lkvc_pkg::QUEUE_DEPTH));
    assign o_valid = (r_count != '0);
    assign o_req   = r_slot[r_rptr];
    assign do_push = i_push & ~o_full;
    assign do_pop  = i_pop & o_valid;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wptr  <= '0;
            r_rptr  <= '0;
            r_count <= '0;
        end else begin
            if (do_push) begin
                r_wptr <= r_wptr + 1'b1;
            end
            if (do_pop) begin
                r_rptr <= r_rptr + 1'b1;
            end
            if (do_push && !do_pop) begin
                r_count <= r_count + 1'b1;
            end else if (do_pop && !do_push) begin
                r_count <= r_count - 1'b1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (do_push) begin
            r_slot[r_wptr] <= i_req;
        end
    end

endmodule

// ----- rtl/core/lkvc_back.sv -----
// Back end: key match over all entries, LRU age update, insert/evict and response.
// Depends on lkvc_pkg; takes requests from lkvc_queue.
module lkvc_back #(
    parameter int ENTRIES = lkvc_pkg::ENTRIES_DEF
) (
    input  logic                                i_clk,
    input  logic                                i_rst_n,
    input  logic [lkvc_pkg::CAP_W-1:0]          i_capacity,
    input  logic                                i_q_valid,
    input  lkvc_pkg::t_req                      i_q_req,
    output logic                                o_q_pop,
    output logic                                o_valid,
    input  logic                                i_stall,
    output logic                                o_hit,
    output logic signed [lkvc_pkg::VALUE_W-1:0] o_data
);

    localparam int IW   = (ENTRIES > 1) ? $clog2(ENTRIES) : 1;
    localparam int CW   = $clog2(ENTRIES + 1);
    localparam int CMPW = (CW > lkvc_pkg::CAP_W) ? CW : lkvc_pkg::CAP_W;

    // entry state: keys and ages are per-entry compare cells, values a memory
    logic                               r_ent_valid [ENTRIES];
    logic [lkvc_pkg::KEY_W-1:0]         r_ent_key   [ENTRIES];
    logic [IW-1:0]                      r_ent_age   [ENTRIES];
    logic [lkvc_pkg::VALUE_W-1:0]       mem_value   [ENTRIES];
    logic [CW-1:0]                      r_count;

    lkvc_pkg::t_back_state r_state;
    lkvc_pkg::t_back_state n_state;

    // latched request and match results
    lkvc_pkg::t_req               r_req;
    logic                         r_hit;
    logic [IW-1:0]                r_idx;
    logic                         r_evict;
    logic [ENTRIES-1:0]           r_victim;
    logic [IW-1:0]                r_slot;
    logic [lkvc_pkg::VALUE_W-1:0] r_rd_data;

    logic                         r_o_valid;
    logic                         r_o_hit;
    logic [lkvc_pkg::VALUE_W-1:0] r_o_data;

    logic [ENTRIES-1:0] hit_vec;
    logic [ENTRIES-1:0] victim_vec;
    logic [IW-1:0]      hit_idx;
    logic [IW-1:0]      free_slot;
    logic [CMPW-1:0]    eff_cap;
    logic [CMPW-1:0]    cap_ext;
    logic               full;
    logic               load_out;
    logic [IW-1:0]      touch_age;

    // match and replacement choice against the queue head
    always_comb begin
        hit_idx   = '0;
        free_slot = '0;
        for (int i = 0; i < ENTRIES; i++) begin
            hit_vec[i]    = r_ent_valid[i] && (r_ent_key[i] == i_q_req.key);
            victim_vec[i] = r_ent_valid[i] && (r_ent_age[i] == IW'(r_count - 1'b1));
            if (hit_vec[i]) begin
                hit_idx = hit_idx | IW'(i);
            end
        end

        cap_ext = CMPW'(i_capacity);
        eff_cap = cap_ext;
        if (cap_ext == '0) begin
            eff_cap = CMPW'(1);
        end else if (cap_ext > CMPW'(ENTRIES)) begin
            eff_cap = CMPW'(ENTRIES);
        end
        full = (CMPW'(r_count) >= eff_cap);

        // lowest free entry, counting the victim as free when evicting
        for (int i = ENTRIES - 1; i >= 0; i--) begin
            if (!r_ent_valid[i] || (full && victim_vec[i])) begin
                free_slot = IW'(i);
            end
        end
    end

    assign touch_age = r_ent_age[r_idx];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= lkvc_pkg::ST_MATCH;
        end else begin
            r_state <= n_state;
        end
    end

    always_comb begin
        n_state  = r_state;
        o_q_pop  = 1'b0;
        load_out = 1'b0;
        case (r_state)
            lkvc_pkg::ST_MATCH: begin
                if (i_q_valid) begin
                    o_q_pop = 1'b1;
                    n_state = lkvc_pkg::ST_UPDATE;
                end
            end
            lkvc_pkg::ST_UPDATE: begin
                n_state = (r_req.op == lkvc_pkg::OP_GET) ? lkvc_pkg::ST_RESP
                                                         : lkvc_pkg::ST_MATCH;
            end
            lkvc_pkg::ST_RESP: begin
                if (!r_o_valid || !i_stall) begin
                    load_out = 1'b1;
                    n_state  = lkvc_pkg::ST_MATCH;
                end
            end
            default: begin
                n_state = lkvc_pkg::ST_MATCH;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (o_q_pop) begin
            r_req    <= i_q_req;
            r_hit    <= |hit_vec;
            r_idx    <= hit_idx;
            r_evict  <= full;
            r_victim <= victim_vec;
            r_slot   <= free_slot;
        end
    end

    // entry state update
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            for (int i = 0; i < ENTRIES; i++) begin
                r_ent_valid[i] <= 1'b0;
                r_ent_age[i]   <= '0;
            end
            r_count <= '0;
        end else if (r_state == lkvc_pkg::ST_UPDATE) begin
            if (r_hit) begin
                // move the hit entry to the front, age the newer ones
                for (int i = 0; i < ENTRIES; i++) begin
                    if (IW'(i) == r_idx) begin
                        r_ent_age[i] <= '0;
                    end else if (r_ent_valid[i] && (r_ent_age[i] < touch_age)) begin
                        r_ent_age[i] <= r_ent_age[i] + 1'b1;
                    end
                end
            end else if (r_req.op == lkvc_pkg::OP_PUT) begin
                for (int i = 0; i < ENTRIES; i++) begin
                    if (IW'(i) == r_slot) begin
                        r_ent_valid[i] <= 1'b1;
                        r_ent_age[i]   <= '0;
                    end else if (r_evict && r_victim[i]) begin
                        r_ent_valid[i] <= 1'b0;
                        r_ent_age[i]   <= '0;
                    end else if (r_ent_valid[i]) begin
                        r_ent_age[i] <= r_ent_age[i] + 1'b1;
                    end
                end
                if (!r_evict) begin
                    r_count <= r_count + 1'b1;
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if ((r_state == lkvc_pkg::ST_UPDATE) && (r_req.op == lkvc_pkg::OP_PUT) && !r_hit) begin
            r_ent_key[r_slot] <= r_req.key;
        end
    end

    // value memory: one write port, one registered read port
    always_ff @(posedge i_clk) begin
        if ((r_state == lkvc_pkg::ST_UPDATE) && (r_req.op == lkvc_pkg::OP_PUT)) begin
            mem_value[r_hit ? r_idx : r_slot] <= r_req.value;
        end
    end

    always_ff @(posedge i_clk) begin
        if ((r_state == lkvc_pkg::ST_UPDATE) && (r_req.op == lkvc_pkg::OP_GET)) begin
            r_rd_data <= mem_value[r_idx];
        end
    end

    // output register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_o_valid <= 1'b0;
        end else if (load_out) begin
            r_o_valid <= 1'b1;
        end else if (!i_stall) begin
            r_o_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (load_out) begin
            r_o_hit  <= r_hit;
            r_o_data <= r_hit ? r_rd_data : lkvc_pkg::MISS_DATA;
        end
    end

    assign o_valid = r_o_valid;
    assign o_hit   = r_o_hit;
    assign o_data  = r_o_data;

endmodule

// ----- rtl/core/lru_key_value_cache_core.sv -----
// LRU key/value cache core: top level with the capacity register port.
// Depends on lkvc_pkg, lkvc_front, lkvc_queue and lkvc_back.
//
// Fully associative store of ENTRIES key/value pairs with least-recently-used
// replacement. A get request (kind 0) returns one result: hit and the stored
// value, or hit clear and data all ones. A put request (kind 1) updates or
// inserts and returns nothing; a new key evicts the least recent entry once the
// entry count reaches the capacity register (0 reads as 1, values above ENTRIES
// as ENTRIES). Requests pass a one-entry input stage and a two-entry queue, so
// several can be taken while the back end works. The back end takes one request
// at a time: a get steps through key match, entry update with value memory read
// and response load (held while the result output stalls), a put through key
// match and entry update only. Write the capacity only while the core is idle.
module lru_key_value_cache_core #(
    parameter int ENTRIES = lkvc_pkg::ENTRIES_DEF
) (
    input  logic                                i_clk,
    input  logic                                i_rst_n,
    // request channel
    input  logic                                i_valid,
    output logic                                o_stall,
    input  logic                                i_kind,
    input  logic signed [lkvc_pkg::KEY_W-1:0]   i_key,
    input  logic signed [lkvc_pkg::VALUE_W-1:0] i_value,
    // result channel
    output logic                                o_valid,
    input  logic                                i_stall,
    output logic                                o_hit,
    output logic signed [lkvc_pkg::VALUE_W-1:0] o_data,
    // register port
    input  logic                                psel,
    input  logic                                penable,
    input  logic                                pwrite,
    input  logic [lkvc_pkg::PADDR_W-1:0]        paddr,
    input  logic [lkvc_pkg::PDATA_W-1:0]        pwdata,
    output logic [lkvc_pkg::PDATA_W-1:0]        prdata,
    output logic                                pready
);

    logic [lkvc_pkg::CAP_W-1:0] r_capacity;
    logic                       reg_sel;
    logic                       push;
    logic                       q_full;
    logic                       q_valid;
    logic                       q_pop;
    lkvc_pkg::t_req             front_req;
    lkvc_pkg::t_req             q_req;

    assign pready  = 1'b1;
    assign reg_sel = (paddr[lkvc_pkg::PADDR_W-1:2] == lkvc_pkg::REG_CAPACITY);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_capacity <= lkvc_pkg::CAP_RESET;
        end else if (psel && penable && pwrite && pready && reg_sel) begin
            r_capacity <= pwdata[lkvc_pkg::CAP_W-1:0];
        end
    end

    always_comb begin
        prdata = '0;
        if (reg_sel) begin
            prdata = lkvc_pkg::PDATA_W'(r_capacity);
        end
    end

    lkvc_front u_front (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_valid  (i_valid),
        .o_stall  (o_stall),
        .i_kind   (i_kind),
        .i_key    (i_key),
        .i_value  (i_value),
        .i_q_full (q_full),
        .o_push   (push),
        .o_req    (front_req)
    );

    lkvc_queue u_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (push),
        .i_req   (front_req),
        .o_full  (q_full),
        .i_pop   (q_pop),
        .o_valid (q_valid),
        .o_req   (q_req)
    );

    lkvc_back #(
        .ENTRIES (ENTRIES)
    ) u_back (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_capacity (r_capacity),
        .i_q_valid  (q_valid),
        .i_q_req    (q_req),
        .o_q_pop    (q_pop),
        .o_valid    (o_valid),
        .i_stall    (i_stall),
        .o_hit      (o_hit),
        .o_data     (o_data)
    );

endmodule

// ----- dv/tb_lru_key_value_cache_core.sv -----
`timescale 1ns / 100ps
// Testbench for lru_key_value_cache_core: directed and random get/put traffic.
// A shadow LRU store predicts every lookup result. Depends on lkvc_pkg.
module tb_lru_key_value_cache_core;
    import lkvc_pkg::*;

    localparam int SLOTS          = ENTRIES_DEF;
    localparam int POOL_SIZE      = 20;
    localparam int SETTLE_CYCLES  = 32;
    localparam int WATCHDOG_LIMIT = 2000;
    localparam logic [PADDR_W-1:0] ADDR_CAPACITY = PADDR_W'(4 * REG_CAPACITY);

    typedef struct packed {
        logic               hit;
        logic [VALUE_W-1:0] data;
    } t_lookup;

    logic                i_clk   = 1'b0;
    logic                i_rst_n = 1'b0;
    logic                i_valid = 1'b0;
    logic                o_stall;
    logic                i_kind  = 1'b0;
    logic [KEY_W-1:0]    i_key   = '0;
    logic [VALUE_W-1:0]  i_value = '0;
    logic                o_valid;
    logic                i_stall = 1'b0;
    logic                o_hit;
    logic [VALUE_W-1:0]  o_data;
    logic                psel    = 1'b0;
    logic                penable = 1'b0;
    logic                pwrite  = 1'b0;
    logic [PADDR_W-1:0]  paddr   = '0;
    logic [PDATA_W-1:0]  pwdata  = '0;
    logic [PDATA_W-1:0]  prdata;
    logic                pready;

    // shadow copy of the store and its capacity register
    logic               shadow_valid [SLOTS];
    logic [KEY_W-1:0]   shadow_key   [SLOTS];
    logic [VALUE_W-1:0] shadow_value [SLOTS];
    int                 shadow_age   [SLOTS];
    int                 shadow_count;
    logic [CAP_W-1:0]   shadow_cap;

    t_lookup            pending_lookups[$];
    logic [KEY_W-1:0]   key_pool [POOL_SIZE];

    int send_idle_pct  = 0;
    int recv_stall_pct = 0;
    int hold_req       = 0;
    int hold_left      = 0;
    int stuck_cycles   = 0;
    int mismatches     = 0;
    int n_req          = 0;
    int n_get          = 0;
    int n_hit          = 0;
    int n_cfg          = 0;

    lru_key_value_cache_core DUT (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_valid (i_valid),
        .o_stall (o_stall),
        .i_kind  (i_kind),
        .i_key   (i_key),
        .i_value (i_value),
        .o_valid (o_valid),
        .i_stall (i_stall),
        .o_hit   (o_hit),
        .o_data  (o_data),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready)
    );

    always #4 i_clk = ~i_clk;

    // Make slot s most recent; slots newer than it age by one.
    function automatic void bump_recency(int s);
        int mark;
        mark = shadow_age[s];
        for (int i = 0; i < SLOTS; i++) begin
            if (shadow_valid[i] && shadow_age[i] < mark) shadow_age[i]++;
        end
        shadow_age[s] = 0;
    endfunction

    function automatic void lru_apply(t_op op, logic [KEY_W-1:0] key,
                                      logic [VALUE_W-1:0] value);
        int      slot;
        int      free_slot;
        int      victim;
        int      limit;
        t_lookup res;
        slot = -1;
        for (int i = 0; i < SLOTS; i++) begin
            if (slot < 0 && shadow_valid[i] && shadow_key[i] == key) slot = i;
        end
        n_req++;
        if (op == OP_GET) begin
            n_get++;
            if (slot >= 0) begin
                bump_recency(slot);
                res.hit  = 1'b1;
                res.data = shadow_value[slot];
                n_hit++;
            end else begin
                res.hit  = 1'b0;
                res.data = MISS_DATA;
            end
            pending_lookups = {pending_lookups, res};
        end else if (slot >= 0) begin
            shadow_value[slot] = value;
            bump_recency(slot);
        end else begin
            // zero reads as one, anything above the slot count saturates
            limit = int'(shadow_cap);
            if (limit < 1) limit = 1;
            if (limit > SLOTS) limit = SLOTS;
            if (shadow_count >= limit) begin
                victim = -1;
                for (int i = 0; i < SLOTS; i++) begin
                    if (shadow_valid[i] &&
                        (victim < 0 || shadow_age[i] > shadow_age[victim])) victim = i;
                end
                if (victim >= 0) begin
                    shadow_valid[victim] = 1'b0;
                    shadow_age[victim]   = 0;
                    if (shadow_count > 0) shadow_count--;
                end
            end
            free_slot = -1;
            for (int i = 0; i < SLOTS; i++) begin
                if (shadow_valid[i]) shadow_age[i]++;
                else if (free_slot < 0) free_slot = i;
            end
            if (free_slot >= 0) begin
                shadow_valid[free_slot] = 1'b1;
                shadow_key[free_slot]   = key;
                shadow_value[free_slot] = value;
                shadow_age[free_slot]   = 0;
                shadow_count++;
            end
        end
    endfunction

    // Offer one request, hold it until accepted, then predict it.
    task automatic send_request(input t_op op, input logic [KEY_W-1:0] key,
                                input logic [VALUE_W-1:0] value);
        while ($urandom_range(99) < send_idle_pct) begin
            i_valid <= 1'b0;
            @(posedge i_clk);
        end
        i_valid <= 1'b1;
        i_kind  <= op;
        i_key   <= key;
        i_value <= value;
        do @(posedge i_clk); while (o_stall !== 1'b0);
        lru_apply(op, key, value);
    endtask

    // Drop valid, wait for every lookup result, then let trailing puts finish.
    task automatic wait_idle();
        i_valid <= 1'b0;
        while (pending_lookups.size() != 0) @(posedge i_clk);
        repeat (SETTLE_CYCLES) @(posedge i_clk);
    endtask

    task automatic write_capacity(input logic [CAP_W-1:0] cap);
        wait_idle();
        psel    <= 1'b1;
        pwrite  <= 1'b1;
        penable <= 1'b0;
        paddr   <= ADDR_CAPACITY;
        pwdata  <= {(PDATA_W-CAP_W)'($urandom()), cap};
        @(posedge i_clk);
        penable <= 1'b1;
        do @(posedge i_clk); while (pready !== 1'b1);
        psel    <= 1'b0;
        penable <= 1'b0;
        pwrite  <= 1'b0;
        shadow_cap = cap;
        n_cfg++;
    endtask

    task automatic run_random(input int count);
        t_op              op;
        logic [KEY_W-1:0] key;
        logic [VALUE_W-1:0] value;
        for (int n = 0; n < count; n++) begin
            op  = ($urandom_range(99) < 45) ? OP_GET : OP_PUT;
            key = ($urandom_range(9) == 0) ? KEY_W'($urandom())
                                           : key_pool[$urandom_range(POOL_SIZE-1)];
            case ($urandom_range(15))
                0:       value = 32'h8000_0000;
                1:       value = 32'h7fff_ffff;
                default: value = VALUE_W'($urandom());
            endcase
            send_request(op, key, value);
        end
    endtask

    task automatic test_directed_basic();
        send_request(OP_GET, 32'h0000_0000, 32'h5a5a_5a5a);   // empty store
        send_request(OP_PUT, 32'h8000_0000, 32'h7fff_ffff);
        send_request(OP_PUT, 32'h7fff_ffff, 32'h8000_0000);
        send_request(OP_PUT, 32'hffff_ffff, 32'h0000_0000);
        send_request(OP_GET, 32'h8000_0000, 32'hffff_ffff);
        send_request(OP_GET, 32'hffff_ffff, 32'h1234_5678);
        send_request(OP_PUT, 32'h7fff_ffff, 32'hffff_ffff);   // overwrite in place
        send_request(OP_GET, 32'h7fff_ffff, 32'h0000_0000);
        send_request(OP_GET, 32'h0000_0000, 32'h0000_0000);
    endtask

    task automatic test_capacity_extremes();
        // zero acts as one, and it drops below the current count
        write_capacity(5'd0);
        send_request(OP_PUT, 32'h0000_0001, 32'h0000_0011);
        send_request(OP_PUT, 32'h0000_0002, 32'h0000_0022);
        send_request(OP_GET, 32'h0000_0001, 32'h0000_0000);
        send_request(OP_GET, 32'h0000_0002, 32'h0000_0000);
        // top of the field saturates to the slot count
        write_capacity(5'd31);
        send_request(OP_PUT, 32'h4000_0000, 32'h5555_5555);
        send_request(OP_PUT, 32'h3fff_ffff, 32'haaaa_aaaa);
        send_request(OP_GET, 32'h0000_0001, 32'h0000_0000);
        send_request(OP_GET, 32'h0000_0002, 32'h0000_0000);
        send_request(OP_GET, 32'h4000_0000, 32'h0000_0000);
        send_request(OP_GET, 32'h3fff_ffff, 32'h0000_0000);
        send_request(OP_PUT, 32'h4000_0000, 32'h0000_0001);
        send_request(OP_GET, 32'h4000_0000, 32'h0000_0000);
    endtask

    task automatic test_random_traffic();
        send_idle_pct  = 23;
        recv_stall_pct = 54;
        write_capacity(5'd16);
        run_random(170);
        send_idle_pct  = 54;
        recv_stall_pct = 23;
        write_capacity(CAP_W'($urandom_range(2, 8)));
        run_random(170);
        write_capacity(5'd1);
        run_random(40);
        send_idle_pct  = 0;
        recv_stall_pct = 0;
        write_capacity(CAP_W'($urandom_range(9, 31)));
        run_random(170);
    endtask

    task automatic test_backpressure();
        send_idle_pct  = 0;
        recv_stall_pct = 0;
        write_capacity(CAP_W'($urandom_range(4, 16)));
        // hold results off long enough for the input to back up
        hold_req = 150;
        run_random(30);
        wait_idle();
        run_random(20);
    endtask

    // result side: random stall, or a counted hold-off when asked
    always @(posedge i_clk) begin
        if (hold_req > 0) begin
            hold_left = hold_req;
            hold_req  = 0;
        end
        if (hold_left > 0) begin
            hold_left = hold_left - 1;
            i_stall <= 1'b1;
        end else begin
            i_stall <= ($urandom_range(99) < recv_stall_pct);
        end
    end

    always @(posedge i_clk) begin : check_result
        t_lookup want;
        if (i_rst_n && o_valid === 1'b1 && i_stall === 1'b0) begin
            if (pending_lookups.size() == 0) begin
                $error("unexpected result: hit %0b data %h", o_hit, o_data);
                mismatches++;
            end else begin
                want = pending_lookups.pop_front();
                if (o_hit !== want.hit) begin
                    $error("hit: expected %0b, actual %0b", want.hit, o_hit);
                    mismatches++;
                end
                if (o_data !== want.data) begin
                    $error("data: expected %h, actual %h", want.data, o_data);
                    mismatches++;
                end
            end
        end
    end

    always @(posedge i_clk) begin
        if ((i_valid && o_stall === 1'b0) || (o_valid === 1'b1 && i_stall === 1'b0)) begin
            stuck_cycles <= 0;
        end else if (stuck_cycles >= WATCHDOG_LIMIT) begin
            $display("Timeout: nothing accepted for %0d cycles", stuck_cycles);
            $display("Mismatches found");
            $finish;
        end else begin
            stuck_cycles <= stuck_cycles + 1;
        end
    end

    initial begin
        for (int i = 0; i < SLOTS; i++) begin
            shadow_valid[i] = 1'b0;
            shadow_key[i]   = '0;
            shadow_value[i] = '0;
            shadow_age[i]   = 0;
        end
        shadow_count = 0;
        shadow_cap   = CAP_RESET;
        for (int i = 0; i < POOL_SIZE; i++) key_pool[i] = KEY_W'($urandom());
        key_pool[0] = 32'h8000_0000;
        key_pool[1] = 32'h7fff_ffff;
        key_pool[2] = 32'h0000_0000;
        key_pool[3] = 32'hffff_ffff;

        repeat (11) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        send_idle_pct  = 23;
        recv_stall_pct = 54;
        test_directed_basic();
        test_capacity_extremes();
        test_random_traffic();
        test_backpressure();
        wait_idle();

        $display("Ran %0d requests: %0d gets with %0d hits, %0d puts, over %0d capacity writes",
                 n_req, n_get, n_hit, n_req - n_get, n_cfg);
        if (mismatches == 0) begin
            $display("No mismatches found");
        end else begin
            $display("Mismatches found");
        end
        $finish;
    end

endmodule
